### sv/tmcw_pkg.sv
// Package with the shared constants, types and helper functions of the text console writer.
`default_nettype none

package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STEP   = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COLX_W = $clog2(COLUMNS + TAB_STEP + 1);
  localparam int ROWX_W = ROW_W + 1;

  localparam int F_CODE = ACT_W;
  localparam int F_ATTR = F_CODE + CHAR_W;
  localparam int F_ROW  = F_ATTR + ATTR_W;
  localparam int F_COL  = F_ROW + ROW_W;
  localparam int IN_BITS    = F_COL + COL_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = CELL_W + COL_W + ROW_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] KEY_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] KEY_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] KEY_ESCAPE  = 8'h1B;
  localparam logic [CHAR_W-1:0] PRINT_LOW   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HIGH  = 8'h7E;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO  = 8'h30;
  localparam logic [ATTR_W-1:0] ESC_MASK    = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT  = 2'd0,
    ACT_ATTR = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scroll;
    logic clr_last;
    logic out_free;
  } dp_status_t;

  // Maps a screen row to its storage row, given the row that is currently on top.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] base);
    logic [ROWX_W-1:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= ROWX_W'(ROWS)) begin
      sum = sum - ROWX_W'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

### sv/tmcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/tmcw_ctrl.sv
// Controller state machine that sequences clearing, item handling and result delivery.
`default_nettype none

module tmcw_ctrl import tmcw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;

  always_comb begin
    cmd.accept   = rdy_r && in_tvalid;
    cmd.clr_step = (state_r == S_CLEAR) || (state_r == S_SCROLL);
    cmd.out_load = (state_r == S_FINISH) && status.out_free;
    state_nxt    = state_r;
    case (state_r)
      S_CLEAR: begin
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = status.scroll ? S_SCROLL : S_FINISH;
      end
      S_SCROLL: begin
        if (status.clr_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    rdy_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  assign in_tready = rdy_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("a second transaction was taken while one was in progress");

  a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("the controller did not return to ready after a result");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && status.clr_last) |=> (in_tready && !cmd.clr_step))
    else $error("the reset clearing pass did not end on its last cell");

endmodule

`default_nettype wire

### sv/tmcw_dp.sv
// Datapath with the cursor, attribute, screen store, clearing counter and result register.
`default_nettype none

module tmcw_dp import tmcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  action_t             act;
  logic [CHAR_W-1:0]   code;
  logic [ATTR_W-1:0]   attr_in;
  logic [ROW_W-1:0]    rrow;
  logic [COL_W-1:0]    rcol;

  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  logic                esc_r, esc_nxt;
  logic [ROW_W-1:0]    base_r, base_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_end_r;
  logic                res_read_r, res_scroll_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [COLX_W-1:0]   col_x;
  logic [ROWX_W-1:0]   row_x;
  logic                print;
  logic                scroll;
  logic                read_ok;
  logic [ADDR_W-1:0]   cur_addr, rd_addr, row_addr;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata, rd_cell;

  assign act     = action_t'(in_tdata[ACT_W-1:0]);
  assign code    = in_tdata[F_CODE +: CHAR_W];
  assign attr_in = in_tdata[F_ATTR +: ATTR_W];
  assign rrow    = in_tdata[F_ROW +: ROW_W];
  assign rcol    = in_tdata[F_COL +: COL_W];

  always_comb begin
    col_x    = COLX_W'(cur_col_r);
    row_x    = {1'b0, cur_row_r};
    esc_nxt  = esc_r;
    attr_nxt = attr_r;
    print    = 1'b0;
    case (act)
      ACT_PUT: begin
        if (esc_r) begin
          attr_nxt = (code - DIGIT_ZERO) & ESC_MASK;
          esc_nxt  = 1'b0;
        end else begin
          if (code == KEY_TAB) begin
            col_x = col_x + COLX_W'(TAB_STEP);
          end else if (code == KEY_NEWLINE) begin
            col_x = '0;
            row_x = row_x + 1'b1;
          end else if (code == KEY_RETURN) begin
            col_x = '0;
          end else if (code == KEY_ESCAPE) begin
            esc_nxt = 1'b1;
          end else if (code >= PRINT_LOW && code <= PRINT_HIGH) begin
            print = 1'b1;
            col_x = col_x + 1'b1;
          end
          if (col_x >= COLX_W'(COLUMNS)) begin
            col_x = '0;
            row_x = row_x + 1'b1;
          end
        end
      end
      ACT_ATTR: begin
        attr_nxt = attr_in;
      end
      default: begin
      end
    endcase
    scroll      = (row_x >= ROWX_W'(ROWS));
    cur_col_nxt = col_x[COL_W-1:0];
    cur_row_nxt = scroll ? ROW_W'(ROWS - 1) : row_x[ROW_W-1:0];
    base_nxt    = (base_r == ROW_W'(ROWS - 1)) ? '0 : base_r + 1'b1;
  end

  assign read_ok  = (act == ACT_READ) && ({1'b0, rrow} < ROWX_W'(ROWS))
                    && ({1'b0, rcol} < (COL_W + 1)'(COLUMNS));
  assign cur_addr = cell_addr(phys_row(cur_row_r, base_r), cur_col_r);
  assign rd_addr  = cell_addr(phys_row(rrow, base_r), rcol);
  assign row_addr = cell_addr(base_r, '0);

  always_comb begin
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.accept && print;
      ram_waddr = cur_addr;
      ram_wdata = {attr_r, code};
    end
  end

  assign ram_re = cmd.accept && read_ok;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      attr_r     <= ATTR_RESET;
      esc_r      <= 1'b0;
      base_r     <= '0;
      clr_addr_r <= '0;
      clr_end_r  <= ADDR_W'(CELL_COUNT - 1);
    end else if (cmd.accept) begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      attr_r    <= attr_nxt;
      esc_r     <= esc_nxt;
      if (scroll) begin
        base_r     <= base_nxt;
        clr_addr_r <= row_addr;
        clr_end_r  <= row_addr + ADDR_W'(COLUMNS - 1);
      end
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_read_r   <= read_ok;
      res_scroll_r <= scroll;
    end
  end

  assign rd_cell = res_read_r ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'({res_scroll_r, cur_row_r, cur_col_r, rd_cell});
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.scroll   = scroll;
  assign status.clr_last = (clr_addr_r == clr_end_r);
  assign status.out_free = !out_valid_r || out_tready;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < COL_W'(COLUMNS)) && ({1'b0, cur_row_r} < ROWX_W'(ROWS))
    && ({1'b0, base_r} < ROWX_W'(ROWS)))
    else $error("cursor or top row left the screen");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("a waiting result was overwritten");

  a_clear_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> (clr_addr_r <= clr_end_r))
    else $error("clearing ran past the end of its range");

endmodule

`default_nettype wire

### sv/text_mode_console_writer.sv
// Top level of the text console writer: a character-cell screen with cursor and scrolling.
//
// The slave channel (in_*) carries one command per transaction: put a character byte,
// load the attribute, or read back one cell. Every command produces exactly one
// transaction on the master channel (out_*) with the cell read (zero for other
// commands and for a read outside the screen), the cursor after the command and a
// flag telling whether it scrolled. Commands are handled one at a time. A command is
// accepted in the idle state, and its result is loaded into the output register in the
// finish state once the register is free; only then is the next command accepted. The
// screen store has one write port and one registered read port; a cell write or read uses it once.
// Scrolling moves a top-row pointer instead of copying rows, and then clears the new
// bottom row through the write port, one cell per cycle, before the result is loaded.
// After reset the block clears all 2000 cells, one per cycle, and in_tready stays low
// until the clearing is done. The cursor starts at the top left and the attribute at 7.
// When the receiver stalls, the result waits in the output register while the next
// command is still accepted and processed; that command then waits until the register
// is taken.
`default_nettype none

module text_mode_console_writer import tmcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // action[1:0], char_code[9:2], attr_value[17:10], read_row[22:18], read_col[29:23]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cell_char[7:0], cell_attr[15:8], cursor_col[22:16], cursor_row[27:23], did_scroll[28]
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tmcw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
